// ===== design/vt4x4_pkg.sv =====
// ----------------------------------------------------------------------------
// vt4x4_pkg
// Shared widths, types and register indexes for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt4x4_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
  localparam int ACC_W     = PROD_W + 2;
  localparam int CFG_W     = 64;
  localparam int IDX_W     = 8;

  localparam logic [IDX_W-1:0] REG_ROW1_FIRST  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ROW1_SECOND = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ROW2_FIRST  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_ROW2_SECOND = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_ROW3_FIRST  = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_ROW3_SECOND = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_ROW4_FIRST  = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_ROW4_SECOND = IDX_W'(7);

  localparam logic [CFG_W-1:0] ONE_LOW  = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] ONE_HIGH = 64'h0001_0000_0000_0000;

  typedef logic signed [DATA_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef comp_t vec_t [4];
  typedef comp_t mat_t [4][4];
  typedef prod_t prod_mat_t [4][4];

endpackage

// ===== design/vt4x4_matrix_regs.sv =====
// ----------------------------------------------------------------------------
// vt4x4_matrix_regs
// Configuration registers holding the 4x4 matrix, two entries per register.
// ----------------------------------------------------------------------------
module vt4x4_matrix_regs import vt4x4_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output mat_t             mat
);

  logic [CFG_W-1:0] row1_first;
  logic [CFG_W-1:0] row1_second;
  logic [CFG_W-1:0] row2_first;
  logic [CFG_W-1:0] row2_second;
  logic [CFG_W-1:0] row3_first;
  logic [CFG_W-1:0] row3_second;
  logic [CFG_W-1:0] row4_first;
  logic [CFG_W-1:0] row4_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      row1_first  <= ONE_LOW;
      row1_second <= '0;
      row2_first  <= ONE_HIGH;
      row2_second <= '0;
      row3_first  <= '0;
      row3_second <= ONE_LOW;
      row4_first  <= '0;
      row4_second <= ONE_HIGH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW1_FIRST:  row1_first  <= cfg_data;
        REG_ROW1_SECOND: row1_second <= cfg_data;
        REG_ROW2_FIRST:  row2_first  <= cfg_data;
        REG_ROW2_SECOND: row2_second <= cfg_data;
        REG_ROW3_FIRST:  row3_first  <= cfg_data;
        REG_ROW3_SECOND: row3_second <= cfg_data;
        REG_ROW4_FIRST:  row4_first  <= cfg_data;
        REG_ROW4_SECOND: row4_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mat[0][0] = comp_t'(row1_first[DATA_W-1:0]);
    mat[0][1] = comp_t'(row1_first[CFG_W-1:DATA_W]);
    mat[0][2] = comp_t'(row1_second[DATA_W-1:0]);
    mat[0][3] = comp_t'(row1_second[CFG_W-1:DATA_W]);
    mat[1][0] = comp_t'(row2_first[DATA_W-1:0]);
    mat[1][1] = comp_t'(row2_first[CFG_W-1:DATA_W]);
    mat[1][2] = comp_t'(row2_second[DATA_W-1:0]);
    mat[1][3] = comp_t'(row2_second[CFG_W-1:DATA_W]);
    mat[2][0] = comp_t'(row3_first[DATA_W-1:0]);
    mat[2][1] = comp_t'(row3_first[CFG_W-1:DATA_W]);
    mat[2][2] = comp_t'(row3_second[DATA_W-1:0]);
    mat[2][3] = comp_t'(row3_second[CFG_W-1:DATA_W]);
    mat[3][0] = comp_t'(row4_first[DATA_W-1:0]);
    mat[3][1] = comp_t'(row4_first[CFG_W-1:DATA_W]);
    mat[3][2] = comp_t'(row4_second[DATA_W-1:0]);
    mat[3][3] = comp_t'(row4_second[CFG_W-1:DATA_W]);
  end

endmodule

// ===== design/vt4x4_product_stage.sv =====
// ----------------------------------------------------------------------------
// vt4x4_product_stage
// Sixteen registered 32x32 products, each floor-shifted by the fraction bits.
// ----------------------------------------------------------------------------
module vt4x4_product_stage import vt4x4_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  vec_t      vec,
  input  mat_t      mat,
  input  logic      next_ready,
  output logic      ready,
  output logic      valid,
  output prod_mat_t prod
);

  logic signed [2*DATA_W-1:0] full [4][4];

  assign ready = !valid || next_ready;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        full[r][c] = (2*DATA_W)'(vec[r]) * (2*DATA_W)'(mat[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= prod_t'(full[r][c][2*DATA_W-1:FRAC_BITS]);
        end
      end
    end
  end

endmodule

// ===== design/vt4x4_reduce_stage.sv =====
// ----------------------------------------------------------------------------
// vt4x4_reduce_stage
// Column sums of the products, then saturation into the output register.
// ----------------------------------------------------------------------------
module vt4x4_reduce_stage import vt4x4_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  prod_mat_t prod,
  output logic      ready,
  input  logic      out_stall,
  output logic      out_valid,
  output vec_t      out_vec,
  output logic      out_sat
);

  localparam acc_t ACC_MAX = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic  sum_valid;
  acc_t  acc [4];
  logic  sum_ready;
  logic  out_ready;
  acc_t  acc_next [4];
  vec_t  clamp;
  logic  sat_next;

  assign out_ready = !out_valid || !out_stall;
  assign sum_ready = !sum_valid || out_ready;
  assign ready     = sum_ready;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc_next[c] = acc_t'(prod[0][c]) + acc_t'(prod[1][c])
                  + acc_t'(prod[2][c]) + acc_t'(prod[3][c]);
    end
  end

  always_comb begin
    sat_next = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if (acc[c] > ACC_MAX) begin
        clamp[c] = comp_t'(ACC_MAX[DATA_W-1:0]);
        sat_next = 1'b1;
      end else if (acc[c] < ACC_MIN) begin
        clamp[c] = comp_t'(ACC_MIN[DATA_W-1:0]);
        sat_next = 1'b1;
      end else begin
        clamp[c] = comp_t'(acc[c][DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && in_valid) begin
      acc <= acc_next;
    end
    if (out_ready && sum_valid) begin
      out_vec <= clamp;
      out_sat <= sat_next;
    end
  end

endmodule

// ===== design/vertex_transform_4x4_top.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4_top
// Row vector (x, y, z, w) times a configurable 4x4 Q16.16 matrix, saturated.
// Throughput: one item per cycle while out_stall is low; the four registered
// stages (input, products, column sums, saturation) each hold one item and hold on stall.
// Reset: synchronous; clears all stage valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_top import vt4x4_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  comp_t            in_x,
  input  comp_t            in_y,
  input  comp_t            in_z,
  input  comp_t            in_w,
  output logic             out_valid,
  input  logic             out_stall,
  output comp_t            out_x,
  output comp_t            out_y,
  output comp_t            out_z,
  output comp_t            out_w,
  output logic             saturated
);

  mat_t      mat;
  logic      vin_valid;
  vec_t      vin;
  logic      vin_ready;
  logic      prod_ready;
  logic      prod_valid;
  prod_mat_t prod;
  logic      red_ready;
  vec_t      out_vec;

  assign cfg_ready = 1'b1;

  vt4x4_matrix_regs u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat)
  );

  assign vin_ready = !vin_valid || prod_ready;
  assign in_stall  = !vin_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vin_valid <= 1'b0;
    end else if (vin_ready) begin
      vin_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vin_ready && in_valid) begin
      vin[0] <= in_x;
      vin[1] <= in_y;
      vin[2] <= in_z;
      vin[3] <= in_w;
    end
  end

  vt4x4_product_stage u_product (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (vin_valid),
    .vec        (vin),
    .mat        (mat),
    .next_ready (red_ready),
    .ready      (prod_ready),
    .valid      (prod_valid),
    .prod       (prod)
  );

  vt4x4_reduce_stage u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .prod      (prod),
    .ready     (red_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_vec   (out_vec),
    .out_sat   (saturated)
  );

  assign out_x = out_vec[0];
  assign out_y = out_vec[1];
  assign out_z = out_vec[2];
  assign out_w = out_vec[3];

endmodule

// ===== sim/vertex_transform_4x4_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4_top_tb
// Self-checking bench for the 4x4 Q16.16 vertex transform. A directed table
// covers reset identity, field extremes, saturation both ways, floor rounding,
// the translation row and ignored register indexes. Random vertices follow
// under random matrices, with sender gaps and receiver stalls in phases. Each
// result is checked against its table row or a local fixed-point transform.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_top_tb;
  import vt4x4_pkg::*;

  typedef struct packed {
    comp_t x, y, z, w;
  } vertex_t;

  typedef struct packed {
    comp_t x, y, z, w;
    logic  sat;
  } xform_t;

  typedef enum int {MAT_IDENT, MAT_POS_MAX, MAT_NEG_MAX, MAT_HALF, MAT_XLATE,
                    MAT_RANDOM} mat_kind_e;

  typedef struct {
    mat_kind_e mat;
    vertex_t   v;
    bit        lit;
    xform_t    want;
  } dir_row_t;

  localparam logic [IDX_W-1:0] ROW_REGS [8] = '{REG_ROW1_FIRST, REG_ROW1_SECOND,
    REG_ROW2_FIRST, REG_ROW2_SECOND, REG_ROW3_FIRST, REG_ROW3_SECOND,
    REG_ROW4_FIRST, REG_ROW4_SECOND};
  localparam logic [IDX_W-1:0] BAD_IDX_LOW = IDX_W'(8);
  localparam logic [IDX_W-1:0] BAD_IDX_TOP = '1;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam comp_t  UNIT  = 32'sh0001_0000;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  comp_t            in_x, in_y, in_z, in_w;
  logic             out_valid;
  logic             out_stall;
  comp_t            out_x, out_y, out_z, out_w;
  logic             saturated;

  logic [CFG_W-1:0] mat_shadow [8];
  xform_t           xform_q [$];
  dir_row_t         dir_rows [$];

  int err_count     = 0;
  int results_seen  = 0;
  int sat_seen      = 0;
  int items_sent    = 0;
  int matrix_loads  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_count    = 0;
  int hold_seen     = 0;

  vertex_transform_4x4_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .in_w      (in_w),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic xform_t transform_vertex(input vertex_t v);
    comp_t      vin [4];
    comp_t      col [4];
    logic [63:0] word;
    comp_t      m;
    longint     acc;
    longint     prod;
    xform_t     res;
    vin[0] = v.x;
    vin[1] = v.y;
    vin[2] = v.z;
    vin[3] = v.w;
    res.sat = 1'b0;
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      for (int r = 0; r < 4; r++) begin
        word = mat_shadow[r * 2 + c / 2];
        m = (c % 2) ? word[63:32] : word[31:0];
        prod = longint'(vin[r]) * longint'(m);
        acc += prod >>> FRAC_BITS;
      end
      if (acc > Q_MAX) begin
        acc = Q_MAX;
        res.sat = 1'b1;
      end else if (acc < Q_MIN) begin
        acc = Q_MIN;
        res.sat = 1'b1;
      end
      col[c] = acc[31:0];
    end
    res.x = col[0];
    res.y = col[1];
    res.z = col[2];
    res.w = col[3];
    return res;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(9))
      5, 6, 7: return comp_t'(int'($urandom_range(32'h1F_FFFF)) - 32'sh10_0000);
      8: begin
        case ($urandom_range(4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          3: return '1;
          default: return UNIT;
        endcase
      end
      9: return comp_t'(int'($urandom_range(32'h1_FFFF)) - 32'sh1_0000);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic comp_t rand_entry();
    case ($urandom_range(9))
      0, 1, 2: return comp_t'($urandom);
      8: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      9: return $urandom_range(1) ? UNIT : '0;
      default: return comp_t'(int'($urandom_range(32'h7_FFFF)) - 32'sh4_0000);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < 40)
      $display("tb: mismatch %s at %0t: got %h, expected %h", what, $time, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    xform_t want;
    if (!rst && out_valid && !out_stall) begin
      if (xform_q.size() == 0) begin
        report_mismatch("unexpected item x", out_x, '0);
      end else begin
        want = xform_q.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (out_w !== want.w) report_mismatch("out_w", out_w, want.w);
        if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
        results_seen++;
        if (want.sat) sat_seen++;
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_count) begin
        hold_seen = hold_count;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_vertex(input vertex_t v, input bit lit, input xform_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x     <= v.x;
    in_y     <= v.y;
    in_z     <= v.z;
    in_w     <= v.w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    xform_q.push_back(lit ? want : transform_vertex(v));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (xform_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_ROW4_SECOND) mat_shadow[idx[2:0]] = data;
  endtask

  task automatic load_matrix(input mat_kind_e kind);
    comp_t ent [4][4];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        case (kind)
          MAT_POS_MAX: ent[r][c] = 32'sh7FFF_FFFF;
          MAT_NEG_MAX: ent[r][c] = 32'sh8000_0000;
          MAT_HALF:    ent[r][c] = (r == c) ? 32'sh0000_8000 : '0;
          MAT_RANDOM:  ent[r][c] = rand_entry();
          default:     ent[r][c] = (r == c) ? UNIT : '0;
        endcase
      end
    end
    if (kind == MAT_XLATE) begin
      ent[3][0] = 32'sh000A_0000;
      ent[3][1] = 32'shFFEC_0000;
      ent[3][2] = 32'sh0000_8000;
    end
    drain();
    for (int i = 0; i < 8; i++)
      cfg_write(ROW_REGS[i], {ent[i / 2][(i % 2) * 2 + 1], ent[i / 2][(i % 2) * 2]});
    if (kind == MAT_IDENT || $urandom_range(3) == 0) begin
      cfg_write(BAD_IDX_LOW, {$urandom, $urandom});
      cfg_write(BAD_IDX_TOP, {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
    matrix_loads++;
  endtask

  task automatic add_row(input mat_kind_e k, input comp_t x, input comp_t y,
                         input comp_t z, input comp_t w, input bit lit,
                         input comp_t ex, input comp_t ey, input comp_t ez,
                         input comp_t ew, input logic es);
    dir_row_t row;
    row.mat  = k;
    row.v    = '{x, y, z, w};
    row.lit  = lit;
    row.want = '{ex, ey, ez, ew, es};
    dir_rows.push_back(row);
  endtask

  initial begin
    mat_kind_e cur;
    mat_kind_e pick;
    vertex_t   v;
    int        n;

    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_x      <= '0;
    in_y      <= '0;
    in_z      <= '0;
    in_w      <= '0;
    mat_shadow[0] = ONE_LOW;
    mat_shadow[1] = '0;
    mat_shadow[2] = ONE_HIGH;
    mat_shadow[3] = '0;
    mat_shadow[4] = '0;
    mat_shadow[5] = ONE_LOW;
    mat_shadow[6] = '0;
    mat_shadow[7] = ONE_HIGH;

    add_row(MAT_IDENT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(MAT_IDENT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1,
            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
    add_row(MAT_IDENT, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1,
            32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
    add_row(MAT_IDENT, '1, '1, '1, '1, 1, '1, '1, '1, '1, 0);
    add_row(MAT_IDENT, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0, 1,
            32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0, 0);
    add_row(MAT_POS_MAX, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1);
    add_row(MAT_POS_MAX, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1);
    add_row(MAT_POS_MAX, UNIT, 0, 0, 0, 1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    add_row(MAT_POS_MAX, 32'hFFFF0000, 0, 0, 0, 1,
            32'h80000001, 32'h80000001, 32'h80000001, 32'h80000001, 0);
    add_row(MAT_POS_MAX, 32'h00008000, 32'hFFFF8000, 32'h00000001, '1, 0, 0, 0, 0, 0, 0);
    add_row(MAT_NEG_MAX, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1);
    add_row(MAT_NEG_MAX, UNIT, 0, 0, 0, 1,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    add_row(MAT_NEG_MAX, 32'hFFFF0000, 0, 0, 0, 1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1);
    add_row(MAT_HALF, '1, 1, '1, 1, 1, '1, 0, '1, 0, 0);
    add_row(MAT_HALF, 32'hFFFFFFFD, 3, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0);
    add_row(MAT_XLATE, 0, 0, 0, UNIT, 1,
            32'h000A0000, 32'hFFEC0000, 32'h00008000, UNIT, 0);
    add_row(MAT_XLATE, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(MAT_XLATE, 32'h7FFFFFFF, 0, 0, UNIT, 1,
            32'h7FFFFFFF, 32'hFFEC0000, 32'h00008000, UNIT, 1);
    add_row(MAT_XLATE, 32'h00010000, 32'h00020000, 32'h00030000, 32'hFFFE8000, 0,
            0, 0, 0, 0, 0);
    add_row(MAT_IDENT, 32'hCAFEBABE, 32'h01234567, 32'hFEDCBA98, 32'h00000004, 1,
            32'hCAFEBABE, 32'h01234567, 32'hFEDCBA98, 32'h00000004, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur = MAT_IDENT;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mat != cur) begin
        load_matrix(dir_rows[i].mat);
        cur = dir_rows[i].mat;
      end
      push_vertex(dir_rows[i].v, dir_rows[i].lit, dir_rows[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 27 : 0;
      stall_pct     = (ph == 2) ? 46 : (ph == 3) ? 27 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        pick = ($urandom_range(9) < 7) ? MAT_RANDOM : mat_kind_e'($urandom_range(4));
        load_matrix(pick);
        if (ph == 0 && seg == 0) hold_count++;
        n = $urandom_range(40, 85);
        for (int k = 0; k < n; k++) begin
          v = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
          push_vertex(v, 1'b0, '0);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("tb: %0d vertices sent, %0d results checked (%0d saturated), %0d matrix loads",
             items_sent, results_seen, sat_seen, matrix_loads);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
